/* hw/rtl/ioac_pkg.sv */
// ioac_pkg: shared types for the impulse onset aligned capture core
// result record carried from the step logic to the output buffer
// no dependencies
package ioac_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] RegChannelCount   = 2'd0;
  localparam logic [1:0] RegWatchedChannel = 2'd1;
  localparam logic [1:0] RegBlockFrames    = 2'd2;
  localparam logic [1:0] RegOnsetThreshold = 2'd3;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 23;
  localparam int SampleW  = 24;
  localparam int IndexW   = 13;
  localparam int LatencyW = 32;

  // one result item
  typedef struct packed {
    logic                       write_enable;
    logic [IndexW-1:0]          write_index;
    logic signed [SampleW-1:0]  write_value;
    logic                       onset_found;
    logic                       capture_done;
    logic [IndexW-1:0]          onset_frame;
    logic [LatencyW-1:0]        latency_frames;
  } ioac_result_t;

endpackage

/* hw/rtl/ioac_if.sv */
// ioac_if: valid/ready channel interfaces for samples in and results out
// depends on ioac_pkg for field widths
interface ioac_in_if;
  import ioac_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ioac_out_if;
  import ioac_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      write_enable;
  logic [IndexW-1:0]         write_index;
  logic signed [SampleW-1:0] write_value;
  logic                      onset_found;
  logic                      capture_done;
  logic [IndexW-1:0]         onset_frame;
  logic [LatencyW-1:0]       latency_frames;

  modport source (output valid, output write_enable, output write_index,
                  output write_value, output onset_found, output capture_done,
                  output onset_frame, output latency_frames, input ready);
  modport sink   (input valid, input write_enable, input write_index,
                  input write_value, input onset_found, input capture_done,
                  input onset_frame, input latency_frames, output ready);
endinterface

/* hw/rtl/ioac_out_buf.sv */
// ioac_out_buf: two-entry output buffer (output register plus skid register)
// depends on ioac_pkg for the result record
module ioac_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  ioac_pkg::ioac_result_t push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output ioac_pkg::ioac_result_t pop_data_o
);
  import ioac_pkg::*;

  logic         out_valid_q;
  logic         skid_valid_q;
  ioac_result_t out_data_q;
  ioac_result_t skid_data_q;
  logic         pop;
  logic         push;

  assign pop          = out_valid_q && pop_ready_i;
  assign push_ready_o = !skid_valid_q;
  assign push         = push_valid_i && !skid_valid_q;
  assign pop_valid_o  = out_valid_q;
  assign pop_data_o   = out_data_q;

  // occupancy flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_data_q <= push_data_i;
      end else begin
        skid_data_q <= push_data_i;
      end
    end
  end

endmodule

/* hw/rtl/impulse_onset_aligned_capture_core.sv */
// impulse_onset_aligned_capture_core: threshold triggered capture with onset alignment
// depends on ioac_pkg, ioac_if (ioac_in_if, ioac_out_if) and ioac_out_buf
//
//   channel   dir  handshake      payload
//   smp_i     in   valid/ready    sample (signed 24)
//   res_o     out  valid/ready    write_enable, write_index, write_value, onset_found,
//                                 capture_done, onset_frame, latency_frames
//   cfg_*     in   write enable   cfg_idx_i (2), cfg_data_i (23)
//
// one sample per cycle while the output buffer has room; each result is registered into that buffer at its transfer
// the step logic updates the counters and phase in the cycle of the transfer
// a two-entry output buffer lets one more sample in while a result is stalled
// reset is asynchronous, active low; configuration returns to its reset values
module impulse_onset_aligned_capture_core #(
  parameter int MAX_FRAMES   = 8192,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ioac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ioac_pkg::CfgDataW-1:0] cfg_data_i,
  ioac_in_if.sink                     smp_i,
  ioac_out_if.source                  res_o
);
  import ioac_pkg::*;

  localparam int PW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FXW = ((PW > 14) ? PW : 14) + 1;
  localparam int KW  = ((CW > 4) ? CW : 4) + 1;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_TAIL,
    PH_HEAD,
    PH_DONE
  } phase_e;

  // configuration registers
  logic [3:0]  chan_count_q;
  logic [2:0]  watched_q;
  logic [13:0] block_frames_q;
  logic [22:0] threshold_q;

  // capture state
  phase_e            phase_q, phase_d;
  logic [CW-1:0]     chan_pos_q, chan_pos_d;
  logic [PW-1:0]     frame_pos_q, frame_pos_d;
  logic [IndexW-1:0] onset_q, onset_d;
  logic [LatencyW-1:0] silent_q, silent_d;

  logic              accept;
  logic              buf_ready;
  ioac_result_t      step_res;
  ioac_result_t      buf_res;

  assign accept      = smp_i.valid && buf_ready;
  assign smp_i.ready = buf_ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q   <= 4'd2;
      watched_q      <= 3'd0;
      block_frames_q <= 14'd1024;
      threshold_q    <= 23'd84;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegChannelCount:   chan_count_q   <= cfg_data_i[3:0];
        RegWatchedChannel: watched_q      <= cfg_data_i[2:0];
        RegBlockFrames:    block_frames_q <= cfg_data_i[13:0];
        RegOnsetThreshold: threshold_q    <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // effective channel and frame counts
  logic [KW-1:0]  nch;
  logic [FXW-1:0] nfr;

  always_comb begin
    if (chan_count_q == 4'd0) begin
      nch = KW'(1);
    end else if (KW'(chan_count_q) > KW'(MAX_CHANNELS)) begin
      nch = KW'(MAX_CHANNELS);
    end else begin
      nch = KW'(chan_count_q);
    end
    if (block_frames_q == 14'd0) begin
      nfr = FXW'(1);
    end else if (FXW'(block_frames_q) > FXW'(MAX_FRAMES)) begin
      nfr = FXW'(MAX_FRAMES);
    end else begin
      nfr = FXW'(block_frames_q);
    end
  end

  // one step of the capture for the sample in transfer
  logic                 watched;
  logic [SampleW-1:0]   mag;
  logic [FXW-1:0]       f_ext;
  logic [FXW-1:0]       onset_ext;
  logic [FXW-1:0]       tail_idx;
  logic [FXW-1:0]       head_idx;
  logic [KW-1:0]        chan_next;
  logic [FXW-1:0]       frame_next;
  logic                 we;
  logic [IndexW-1:0]    widx;
  logic signed [SampleW-1:0] wval;

  always_comb begin
    watched   = (KW'(chan_pos_q) == KW'(watched_q)) && (KW'(watched_q) < nch);
    mag       = smp_i.sample[SampleW-1] ? (~smp_i.sample + SampleW'(1)) : smp_i.sample;
    f_ext     = FXW'(frame_pos_q);
    onset_ext = FXW'(onset_q);
    tail_idx  = f_ext - onset_ext;
    head_idx  = nfr - onset_ext + f_ext;
    chan_next = KW'(chan_pos_q) + KW'(1);
    frame_next = f_ext + FXW'(1);

    phase_d     = phase_q;
    chan_pos_d  = chan_pos_q;
    frame_pos_d = frame_pos_q;
    onset_d     = onset_q;
    silent_d    = silent_q;
    we          = 1'b0;
    widx        = '0;
    wval        = '0;

    if (phase_q != PH_DONE) begin
      // onset search and aligned writes on the watched channel
      if (watched) begin
        unique case (phase_q)
          PH_SEARCH: begin
            if (mag > {1'b0, threshold_q}) begin
              onset_d = f_ext[IndexW-1:0];
              phase_d = PH_TAIL;
              we      = 1'b1;
              wval    = smp_i.sample;
            end else if (silent_q != '1) begin
              silent_d = silent_q + LatencyW'(1);
            end
          end
          PH_TAIL: begin
            if (f_ext >= onset_ext) begin
              we   = 1'b1;
              widx = tail_idx[IndexW-1:0];
              wval = smp_i.sample;
            end
          end
          default: begin
            if (f_ext < onset_ext) begin
              we   = 1'b1;
              widx = head_idx[IndexW-1:0];
              wval = smp_i.sample;
            end
          end
        endcase
      end

      // channel and frame counters, phase change at block end
      if (chan_next >= nch) begin
        chan_pos_d = '0;
        if (frame_next >= nfr) begin
          frame_pos_d = '0;
          if (phase_d == PH_TAIL) begin
            phase_d = (onset_d != '0) ? PH_HEAD : PH_DONE;
          end else if (phase_d == PH_HEAD) begin
            phase_d = PH_DONE;
          end
        end else begin
          frame_pos_d = frame_next[PW-1:0];
        end
      end else begin
        chan_pos_d = chan_next[CW-1:0];
      end
    end

    step_res.write_enable   = we;
    step_res.write_index    = widx;
    step_res.write_value    = wval;
    step_res.onset_found    = (phase_d != PH_SEARCH);
    step_res.capture_done   = (phase_d == PH_DONE);
    step_res.onset_frame    = (phase_d != PH_SEARCH) ? onset_d : '0;
    step_res.latency_frames = (phase_d != PH_SEARCH) ? silent_d : '0;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEARCH;
      chan_pos_q  <= '0;
      frame_pos_q <= '0;
      onset_q     <= '0;
      silent_q    <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      chan_pos_q  <= chan_pos_d;
      frame_pos_q <= frame_pos_d;
      onset_q     <= onset_d;
      silent_q    <= silent_d;
    end
  end

  // result buffer
  ioac_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (smp_i.valid),
    .push_ready_o (buf_ready),
    .push_data_i  (step_res),
    .pop_valid_o  (res_o.valid),
    .pop_ready_i  (res_o.ready),
    .pop_data_o   (buf_res)
  );

  assign res_o.write_enable   = buf_res.write_enable;
  assign res_o.write_index    = buf_res.write_index;
  assign res_o.write_value    = buf_res.write_value;
  assign res_o.onset_found    = buf_res.onset_found;
  assign res_o.capture_done   = buf_res.capture_done;
  assign res_o.onset_frame    = buf_res.onset_frame;
  assign res_o.latency_frames = buf_res.latency_frames;

  // checks
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("capture left the done phase");

  a_onset_zero_searching: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SEARCH |-> onset_q == '0)
    else $error("onset position set while still searching");

  a_write_needs_onset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.write_enable |-> res_o.onset_found)
    else $error("aligned write before any onset");

  a_done_needs_onset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.capture_done |-> res_o.onset_found)
    else $error("capture done without onset");

  a_stall_no_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !smp_i.ready |=> $stable(frame_pos_q) && $stable(chan_pos_q))
    else $error("counters moved while input was stalled");

endmodule
